[rtl/itrt_pkg.sv]
// itrt_pkg: shared constants, types and helper functions for the radix text unit
// used by every module of the unit but itrt_ram; depends on nothing
`timescale 1ns / 1ps

package itrt_pkg;

  localparam int VALUE_W    = 64;
  localparam int RADIX_W    = 6;
  localparam int LIMIT_W    = 7;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 7'd64;

  localparam logic [CHAR_W-1:0] CODE_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CODE_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CODE_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CODE_TEN     = 7'd10;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LETTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_LIMIT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic read;
    logic out_char;
    logic out_empty;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic more_digits;
    logic limit_zero;
    logic last_emit;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d_ext < CODE_TEN) begin
      return CODE_ZERO + d_ext;
    end
    return (upper ? CODE_UPPER_A : CODE_LOWER_A) + d_ext - CODE_TEN;
  endfunction

endpackage

[rtl/integer_to_radix_text_unit.sv]
// integer_to_radix_text_unit: one number in, its radix digits out, one word each
// steps: per digit, 16 divider steps of 4 bits each, then a store; per char, a ram read,
// then an output load that waits while the output is held; one number at a time, with an
// empty word in place of chars when the char limit is zero
// reset: synchronous, active high; radix 10, lower case, limit 64, output empty
// depends on itrt_pkg, itrt_ctrl, itrt_datapath, itrt_ram
`timescale 1ns / 1ps

module integer_to_radix_text_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // number[63:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // char_code[6:0], zero pad
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser,  // empty_res
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [itrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrt_pkg::CFG_DATA_W-1:0] cfg_data
);

  itrt_pkg::cmd_t              cmd;
  itrt_pkg::status_t           status;
  logic [itrt_pkg::CHAR_W-1:0] out_code;

  assign cfg_ready = 1'b1;

  itrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  itrt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .number   (s_axis_tdata),
    .cfg_we   (cfg_valid),
    .cfg_idx  (cfg_index),
    .cfg_wdata(cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_code (out_code),
    .out_last (m_axis_tlast),
    .out_empty(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_code};

endmodule

[rtl/itrt_ram.sv]
// itrt_ram: generic single-port-write, single-port-read ram with registered read
// standalone; no package needed
`timescale 1ns / 1ps

module itrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/itrt_datapath.sv]
// itrt_datapath: config registers, radix divider, digit store and output register
// depends on itrt_pkg and itrt_ram
`timescale 1ns / 1ps

module itrt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  itrt_pkg::cmd_t                  cmd,
  output itrt_pkg::status_t               status,
  input  logic [itrt_pkg::VALUE_W-1:0]    number,
  input  logic                            cfg_we,
  input  logic [itrt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [itrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]     out_code,
  output logic                            out_last,
  output logic                            out_empty
);

  logic [itrt_pkg::RADIX_W-1:0] radix;
  logic                         upper_letters;
  logic [itrt_pkg::LIMIT_W-1:0] char_limit;

  logic [itrt_pkg::RADIX_W-1:0] base;
  logic [itrt_pkg::VALUE_W-1:0] value;
  logic [itrt_pkg::VALUE_W-1:0] value_next;
  logic [itrt_pkg::DIGIT_W-1:0] rem;
  logic [itrt_pkg::DIGIT_W-1:0] rem_next;
  logic [itrt_pkg::DIGIT_W:0]   trial;
  logic [itrt_pkg::STEP_W-1:0]  step_cnt;
  logic [itrt_pkg::COUNT_W-1:0] digit_count;
  logic [itrt_pkg::COUNT_W-1:0] count_inc;
  logic [itrt_pkg::ADDR_W-1:0]  rd_addr;
  logic [itrt_pkg::COUNT_W-1:0] remain;
  logic [itrt_pkg::DIGIT_W-1:0] rd_digit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= itrt_pkg::RADIX_DEFAULT;
      upper_letters <= 1'b0;
      char_limit    <= itrt_pkg::LIMIT_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_idx)
        itrt_pkg::REG_RADIX:         radix <= cfg_wdata[itrt_pkg::RADIX_W-1:0];
        itrt_pkg::REG_UPPER_LETTERS: upper_letters <= cfg_wdata[0];
        itrt_pkg::REG_CHAR_LIMIT:    char_limit <= cfg_wdata[itrt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign base = (radix < itrt_pkg::RADIX_MIN || radix > itrt_pkg::RADIX_MAX) ?
                itrt_pkg::RADIX_DEFAULT : radix;

  // restoring division, DIV_BITS (4) quotient bits per divider step
  always_comb begin
    value_next = value;
    rem_next   = rem;
    trial      = '0;
    for (int i = 0; i < itrt_pkg::DIV_BITS; i++) begin
      trial      = {rem_next, value_next[itrt_pkg::VALUE_W-1]};
      value_next = {value_next[itrt_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial         = trial - {1'b0, base};
        value_next[0] = 1'b1;
      end
      rem_next = trial[itrt_pkg::DIGIT_W-1:0];
    end
  end

  assign count_inc = digit_count + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value       <= number;
      rem         <= '0;
      step_cnt    <= '0;
      digit_count <= '0;
    end else if (cmd.div_step) begin
      value    <= value_next;
      rem      <= rem_next;
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.store) begin
      rem         <= '0;
      step_cnt    <= '0;
      digit_count <= count_inc;
      rd_addr     <= digit_count[itrt_pkg::ADDR_W-1:0];
      if (itrt_pkg::LIMIT_W'(count_inc) > char_limit) begin
        remain <= itrt_pkg::COUNT_W'(char_limit);
      end else begin
        remain <= count_inc;
      end
    end else if (cmd.out_char) begin
      rd_addr <= rd_addr - 1'b1;
      remain  <= remain - 1'b1;
    end
  end

  itrt_ram #(
    .WIDTH(itrt_pkg::DIGIT_W),
    .DEPTH(itrt_pkg::MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(digit_count[itrt_pkg::ADDR_W-1:0]),
    .wdata(rem),
    .re   (cmd.read),
    .raddr(rd_addr),
    .rdata(rd_digit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_char || cmd.out_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_char) begin
      out_code  <= itrt_pkg::digit_char(rd_digit, upper_letters);
      out_last  <= (remain == itrt_pkg::COUNT_W'(1));
      out_empty <= 1'b0;
    end else if (cmd.out_empty) begin
      out_code  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  assign status.step_done   = (step_cnt == itrt_pkg::STEP_W'(itrt_pkg::DIV_STEPS - 1));
  assign status.more_digits = (value != '0) &&
                              (count_inc < itrt_pkg::COUNT_W'(itrt_pkg::MAX_DIGITS));
  assign status.limit_zero  = (char_limit == '0);
  assign status.last_emit   = (remain == itrt_pkg::COUNT_W'(1));
  assign status.out_free    = !out_valid || out_ready;

endmodule

[rtl/itrt_ctrl.sv]
// itrt_ctrl: sequencer for divide, store and emit phases
// depends on itrt_pkg
`timescale 1ns / 1ps

module itrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itrt_pkg::status_t status,
  output itrt_pkg::cmd_t    cmd
);

  itrt_pkg::state_t state;
  itrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      itrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = itrt_pkg::ST_DIV;
        end
      end
      itrt_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_done) begin
          state_next = itrt_pkg::ST_STORE;
        end
      end
      itrt_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (status.more_digits) begin
          state_next = itrt_pkg::ST_DIV;
        end else if (status.limit_zero) begin
          state_next = itrt_pkg::ST_EMPTY;
        end else begin
          state_next = itrt_pkg::ST_READ;
        end
      end
      itrt_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = itrt_pkg::ST_LOAD;
      end
      itrt_pkg::ST_LOAD: begin
        if (status.out_free) begin
          cmd.out_char = 1'b1;
          state_next   = status.last_emit ? itrt_pkg::ST_IDLE : itrt_pkg::ST_READ;
        end
      end
      itrt_pkg::ST_EMPTY: begin
        if (status.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = itrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
